@@ hdl/ftwm_pkg.sv @@
// shared constants, codes and types of the frame time window monitor
// no dependencies; used by ftwm_div and frame_time_window_monitor

package ftwm_pkg;

  // field widths fixed by the interface
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned WIN_W          = 9;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned RING_DEPTH_DEF = 256;

  // register reset values
  localparam logic [DATA_W-1:0] BUDGET_RST = 32'd16667;
  localparam logic [WIN_W-1:0]  WINDOW_RST = 9'd256;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  // input word opcodes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/ftwm_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
// depends on ftwm_pkg (div_stat_t)

module ftwm_div #(
  parameter int unsigned SUM_W = 40,
  parameter int unsigned DIV_W = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SUM_W-1:0]      dividend_i,
  input  logic [DIV_W-1:0]      divisor_i,
  output logic [SUM_W-1:0]      quotient_o,
  output ftwm_pkg::div_stat_t   stat_o
);

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] dsr_q, dsr_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;
  logic             fits;

  // shift the next dividend bit into the partial remainder and try the subtract
  assign trial = {rem_q, dsr_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dsr_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CNT_W'(SUM_W);
      run_d = 1'b1;
    end else if (run_q) begin
      // quotient bits enter at the bottom as dividend bits leave the top
      dsr_d = {dsr_q[SUM_W-2:0], fits};
      rem_d = fits ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = dsr_q;
  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;

`ifndef SYNTHESIS
  // remainder stays below the divisor while dividing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (rem_q < dvs_q))
    else $error("ftwm_div: remainder not below divisor");

  // done follows the last step only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!run_q && $past(run_q)))
    else $error("ftwm_div: done without a finishing step");

  // a start while running would lose an operation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q)
    else $error("ftwm_div: start while busy");
`endif

endmodule

@@ hdl/frame_time_window_monitor.sv @@
// frame time window monitor top level: sample ring, window sum, sequencer
// depends on ftwm_pkg and ftwm_div

// Usage
//   Input channel (in_valid_i / in_stall_o): one word per frame event, op_i
//   selects record (frame_us_i is stored) or clear (all history and counters
//   drop to zero, registers keep their values). Output channel (out_valid_o /
//   out_stall_i): one word per input word with last duration, windowed
//   average, over-budget flag, violation count and stored sample count.
//   Config channel (cfg_valid_i / cfg_ready_o): index 0 budget, index 1
//   window; always ready, to be written only while the block is idle.
//   A record passes an evict step when the oldest sample leaves the window,
//   then the divider start and the bit-serial divide of the window sum,
//   SUM_W = 32 + clog2(RING_DEPTH) quotient bits, then the final step.
//   After a window change the first record resums the window from the ring,
//   one sample per cycle, before the divide.
//   A clear goes straight to the final step. The input is free again in
//   the same cycle that the result appears.
//   One word is in work at a time; a finished result waits in the output
//   register while the next word is accepted and processed. If the receiver
//   stalls, the next result holds in its final step until the register frees.
//   Reset zeroes all history and sets budget 16667 and window 256.

module frame_time_window_monitor #(
  parameter int unsigned RING_DEPTH = ftwm_pkg::RING_DEPTH_DEF,
  localparam int unsigned CW = $clog2(RING_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [ftwm_pkg::DATA_W-1:0]         frame_us_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ftwm_pkg::DATA_W-1:0]         last_us_o,
  output logic [ftwm_pkg::DATA_W-1:0]         average_us_o,
  output logic                                over_budget_o,
  output logic [ftwm_pkg::DATA_W-1:0]         violations_o,
  output logic [CW-1:0]                       stored_count_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ftwm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ftwm_pkg::DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned DW    = ftwm_pkg::DATA_W;
  localparam int unsigned WW    = ftwm_pkg::WIN_W;
  localparam int unsigned PW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SUM_W = DW + PW;
  localparam int unsigned MW    = (CW > WW) ? CW : WW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVICT = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DIVS  = 3'd3;
  localparam logic [2:0] ST_DIVW  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  // state
  logic [2:0]       state_q, state_d;
  logic [DW-1:0]    budget_q, budget_d;
  logic [WW-1:0]    window_q, window_d;
  logic [PW-1:0]    wp_q, wp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    nsum_q, nsum_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [DW-1:0]    last_q, last_d;
  logic [DW-1:0]    viol_q, viol_d;
  logic             flag_q, flag_d;
  logic [PW-1:0]    ra_q, ra_d;
  logic [CW-1:0]    left_q, left_d;
  logic             rdv_q, rdv_d;
  logic             out_valid_q, out_valid_d;
  logic [DW-1:0]    out_last_q, out_avg_q, out_viol_q;
  logic             out_flag_q;
  logic [CW-1:0]    out_cnt_q;

  // sample ring
  logic [DW-1:0]    ring [RING_DEPTH];
  logic [DW-1:0]    rd_q;
  logic [PW-1:0]    mem_ra;
  logic             mem_we;

  // helpers
  logic             in_acc;
  logic             out_free;
  logic [PW-1:0]    wp_inc;
  logic [CW-1:0]    cnt_inc;
  logic [MW-1:0]    win_eff;
  logic [CW-1:0]    n_new;
  logic [CW:0]      evict_x;
  logic [PW-1:0]    evict_addr;
  logic [PW-1:0]    ra_dec;
  logic [SUM_W-1:0] quot;
  ftwm_pkg::div_stat_t div_stat;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // ring pointer and stored count after a record
  assign wp_inc  = (wp_q == PW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign cnt_inc = (cnt_q < CW'(RING_DEPTH)) ? cnt_q + 1'b1 : cnt_q;

  // window clipped to at least one and at most the stored count
  assign win_eff = (window_q == '0) ? MW'(1) : MW'(window_q);
  assign n_new   = (win_eff >= MW'(cnt_inc)) ? cnt_inc : CW'(win_eff);

  // slot of the sample that drops out of a full window
  assign evict_x    = ((CW + 1)'(wp_q) >= (CW + 1)'(nsum_q))
                      ? (CW + 1)'(wp_q) - (CW + 1)'(nsum_q)
                      : (CW + 1)'(wp_q) + (CW + 1)'(RING_DEPTH) - (CW + 1)'(nsum_q);
  assign evict_addr = PW'(evict_x);
  assign ra_dec     = (ra_q == '0) ? PW'(RING_DEPTH - 1) : ra_q - 1'b1;

  assign mem_we = in_acc && (op_i == ftwm_pkg::OP_RECORD);
  assign mem_ra = (state_q == ST_SWEEP) ? ra_q : evict_addr;

  // ring memory, read-before-write on the same slot
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring[wp_q] <= frame_us_i;
    end
    rd_q <= ring[mem_ra];
  end

  // sequencer and window sum
  always_comb begin
    state_d     = state_q;
    budget_d    = budget_q;
    window_d    = window_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    nsum_d      = nsum_q;
    sum_d       = sum_q;
    last_d      = last_q;
    viol_d      = viol_q;
    flag_d      = flag_q;
    ra_d        = ra_q;
    left_d      = left_q;
    rdv_d       = rdv_q;
    out_valid_d = out_valid_q && out_stall_i;

    // register writes
    if (cfg_valid_i) begin
      if (cfg_index_i == ftwm_pkg::CFG_BUDGET) begin
        budget_d = cfg_data_i;
      end else if (cfg_index_i == ftwm_pkg::CFG_WINDOW) begin
        window_d = cfg_data_i[WW-1:0];
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == ftwm_pkg::OP_CLEAR) begin
            wp_d    = '0;
            cnt_d   = '0;
            nsum_d  = '0;
            sum_d   = '0;
            last_d  = '0;
            viol_d  = '0;
            flag_d  = 1'b0;
            state_d = ST_FIN;
          end else begin
            last_d = frame_us_i;
            wp_d   = wp_inc;
            cnt_d  = cnt_inc;
            nsum_d = n_new;
            flag_d = frame_us_i > budget_q;
            if ((frame_us_i > budget_q) && (viol_q != '1)) begin
              viol_d = viol_q + 1'b1;
            end
            // grow the window, slide it, or resum after a window change
            priority if ((CW + 1)'(n_new) == (CW + 1)'(nsum_q) + 1'b1) begin
              sum_d   = sum_q + SUM_W'(frame_us_i);
              state_d = ST_DIVS;
            end else if (n_new == nsum_q) begin
              sum_d   = sum_q + SUM_W'(frame_us_i);
              state_d = ST_EVICT;
            end else begin
              sum_d   = '0;
              ra_d    = wp_q;
              left_d  = n_new;
              rdv_d   = 1'b0;
              state_d = ST_SWEEP;
            end
          end
        end
      end
      ST_EVICT: begin
        sum_d   = sum_q - SUM_W'(rd_q);
        state_d = ST_DIVS;
      end
      ST_SWEEP: begin
        // one read issued and one sample added per cycle
        rdv_d = (left_q != '0);
        if (left_q != '0) begin
          ra_d   = ra_dec;
          left_d = left_q - 1'b1;
        end
        if (rdv_q) begin
          sum_d = sum_q + SUM_W'(rd_q);
        end
        if ((left_q == '0) && !rdv_q) begin
          state_d = ST_DIVS;
        end
      end
      ST_DIVS: begin
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_stat.done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      budget_q    <= ftwm_pkg::BUDGET_RST;
      window_q    <= ftwm_pkg::WINDOW_RST;
      wp_q        <= '0;
      cnt_q       <= '0;
      nsum_q      <= '0;
      sum_q       <= '0;
      last_q      <= '0;
      viol_q      <= '0;
      flag_q      <= 1'b0;
      ra_q        <= '0;
      left_q      <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      budget_q    <= budget_d;
      window_q    <= window_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      nsum_q      <= nsum_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      viol_q      <= viol_d;
      flag_q      <= flag_d;
      ra_q        <= ra_d;
      left_q      <= left_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word register, loaded when the previous word has left
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && out_free) begin
      out_last_q <= last_q;
      out_avg_q  <= (cnt_q == '0) ? '0 : quot[DW-1:0];
      out_flag_q <= flag_q;
      out_viol_q <= viol_q;
      out_cnt_q  <= cnt_q;
    end
  end

  // average = window sum / number of samples in the window
  ftwm_div #(
    .SUM_W (SUM_W),
    .DIV_W (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DIVS),
    .dividend_i (sum_q),
    .divisor_i  (nsum_q),
    .quotient_o (quot),
    .stat_o     (div_stat)
  );

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign last_us_o      = out_last_q;
  assign average_us_o   = out_avg_q;
  assign over_budget_o  = out_flag_q;
  assign violations_o   = out_viol_q;
  assign stored_count_o = out_cnt_q;
  assign cfg_ready_o    = 1'b1;

`ifndef SYNTHESIS
  // the window sum never spans more samples than are stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nsum_q <= cnt_q)
    else $error("ftwm: window wider than stored count");

  // before the ring wraps the write pointer equals the stored count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < CW'(RING_DEPTH)) |-> (CW'(wp_q) == cnt_q))
    else $error("ftwm: write pointer out of step with count");

  // an accepted word always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != ST_IDLE))
    else $error("ftwm: accepted word dropped");

  // the divider runs only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == ST_DIVW))
    else $error("ftwm: divider active outside its wait step");
`endif

endmodule
